// ===== hdl/perlin_noise_3d_octaves_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PERLIN_NOISE_3D_OCTAVES_UNIT_MACROS_SVH
`define PERLIN_NOISE_3D_OCTAVES_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PNO_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PNO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pno_pkg.sv =====
`default_nettype none

package pno_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 8;
    localparam int TABLE_SIZE  = 256;
    localparam int DIV_STEPS   = 20;

    // Input commands
    localparam logic CMD_EVAL  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_OCTAVES   = 2'd0,
        CFG_PERSIST   = 2'd1,
        CFG_NORMALIZE = 2'd2
    } t_cfg_idx;

    typedef logic        [16:0] t_wt;    // fade weight, unsigned Q1.16
    typedef logic signed [16:0] t_crd;   // corner offset, -1..1 in Q16
    typedef logic signed [18:0] t_val;   // gradient and lerp values
    typedef logic signed [37:0] t_prod;  // weight times value
    typedef logic signed [23:0] t_tot;   // weighted octave sum
    typedef logic        [19:0] t_asum;  // amplitude sum
    typedef logic        [16:0] t_amp;   // amplitude, up to 1.0

    typedef struct packed {
        t_tot  total;
        t_asum amp_sum;
    } t_acc;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OCT, ST_RD_A, ST_RD_B, ST_RD_AA, ST_RD_AB, ST_RD_BA, ST_RD_BB,
        ST_GRAD, ST_L1M, ST_L1A, ST_L2M, ST_L2A, ST_L3M, ST_L3A, ST_ACCM, ST_ACCA,
        ST_FIN
    } t_eng_st;

    typedef enum logic [1:0] {
        DV_IDLE, DV_RUN, DV_FIN, DV_HOLD
    } t_div_st;

    // Gradient dot product from the low four hash bits
    function automatic t_val grad(input logic [7:0] hash, input t_crd x,
                                  input t_crd y, input t_crd z);
        logic [3:0] h;
        t_val u;
        t_val v;
        h = hash[3:0];
        u = (h < 4'd8) ? t_val'(x) : t_val'(y);
        if (h < 4'd4)
            v = t_val'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = t_val'(x);
        else
            v = t_val'(z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // Second half of a lerp: a + floor(p / 2^16)
    function automatic t_val lerp_add(input t_val a, input t_prod p);
        t_prod s;
        s = p >>> FRAC_BITS;
        return a + t_val'(s);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pno_ram.sv =====
`default_nettype none

module pno_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

`default_nettype wire

// ===== hdl/pno_engine.sv =====
`default_nettype none

module pno_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_cx,
    input  wire logic [31:0]        i_cy,
    input  wire logic [31:0]        i_cz,
    input  wire logic [3:0]         i_octaves,
    input  wire logic [15:0]        i_persistence,
    input  wire logic [7:0]         i_rdata0,
    input  wire logic [7:0]         i_rdata1,
    output logic      [7:0]         o_raddr0,
    output logic      [7:0]         o_raddr1,
    output logic                    o_done,
    output pno_pkg::t_acc           o_acc
);

    pno_pkg::t_eng_st r_state, n_state;

    // Only 8 integer bits and the fraction matter
    logic [23:0] r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic [3:0]  r_oct, n_oct;

    // Fade lanes: x, y, z
    logic [15:0]  r_t2   [3], n_t2   [3];
    logic [15:0]  r_t3   [3], n_t3   [3];
    logic [20:0]  r_poly [3], n_poly [3];
    pno_pkg::t_wt r_fade [3], n_fade [3];

    // Hash chain
    logic [7:0] r_b, n_b, r_aa, n_aa, r_ab, n_ab, r_ba, n_ba, r_bb, n_bb;
    logic [7:0] r_h [6], n_h [6];
    logic [7:0] hh  [8];

    pno_pkg::t_val  r_g [8], n_g [8];
    pno_pkg::t_prod r_p [4], n_p [4];
    pno_pkg::t_val  r_l [4], n_l [4];

    pno_pkg::t_prod r_sp, n_sp;
    logic [32:0]    r_ampn, n_ampn;
    pno_pkg::t_amp  r_amp, n_amp;
    pno_pkg::t_tot  r_total, n_total;
    pno_pkg::t_asum r_asum, n_asum;

    logic [15:0]   fr [3];
    pno_pkg::t_crd cx0, cx1, cy0, cy1, cz0, cz1;
    logic [7:0]    cell_x, cell_y, cell_z;

    assign fr[0]  = r_sx[15:0];
    assign fr[1]  = r_sy[15:0];
    assign fr[2]  = r_sz[15:0];
    assign cell_x = r_sx[23:16];
    assign cell_y = r_sy[23:16];
    assign cell_z = r_sz[23:16];

    // Corner offsets: frac and frac - 1
    assign cx0 = pno_pkg::t_crd'({1'b0, r_sx[15:0]});
    assign cx1 = pno_pkg::t_crd'({1'b1, r_sx[15:0]});
    assign cy0 = pno_pkg::t_crd'({1'b0, r_sy[15:0]});
    assign cy1 = pno_pkg::t_crd'({1'b1, r_sy[15:0]});
    assign cz0 = pno_pkg::t_crd'({1'b0, r_sz[15:0]});
    assign cz1 = pno_pkg::t_crd'({1'b1, r_sz[15:0]});

    // Last two hashes come straight off the read ports
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            hh[k] = r_h[k];
        end
        hh[6] = i_rdata0;
        hh[7] = i_rdata1;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pno_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_sz    <= n_sz;
        r_oct   <= n_oct;
        r_t2    <= n_t2;
        r_t3    <= n_t3;
        r_poly  <= n_poly;
        r_fade  <= n_fade;
        r_b     <= n_b;
        r_aa    <= n_aa;
        r_ab    <= n_ab;
        r_ba    <= n_ba;
        r_bb    <= n_bb;
        r_h     <= n_h;
        r_g     <= n_g;
        r_p     <= n_p;
        r_l     <= n_l;
        r_sp    <= n_sp;
        r_ampn  <= n_ampn;
        r_amp   <= n_amp;
        r_total <= n_total;
        r_asum  <= n_asum;
    end

    // Octave sequencer
    always_comb begin
        logic [31:0] sq;
        logic [31:0] cu;
        logic [36:0] fp;
        logic [7:0]  ha;
        logic signed [19:0] d;

        sq      = '0;
        cu      = '0;
        fp      = '0;
        ha      = '0;
        d       = '0;
        n_state = r_state;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_sz    = r_sz;
        n_oct   = r_oct;
        n_t2    = r_t2;
        n_t3    = r_t3;
        n_poly  = r_poly;
        n_fade  = r_fade;
        n_b     = r_b;
        n_aa    = r_aa;
        n_ab    = r_ab;
        n_ba    = r_ba;
        n_bb    = r_bb;
        n_h     = r_h;
        n_g     = r_g;
        n_p     = r_p;
        n_l     = r_l;
        n_sp    = r_sp;
        n_ampn  = r_ampn;
        n_amp   = r_amp;
        n_total = r_total;
        n_asum  = r_asum;
        o_raddr0 = '0;
        o_raddr1 = '0;
        o_done   = 1'b0;

        unique case (r_state)
            pno_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_sx    = i_cx[23:0];
                    n_sy    = i_cy[23:0];
                    n_sz    = i_cz[23:0];
                    n_oct   = '0;
                    n_amp   = pno_pkg::t_amp'(1 << pno_pkg::FRAC_BITS);
                    n_total = '0;
                    n_asum  = '0;
                    n_state = pno_pkg::ST_OCT;
                end
            end
            pno_pkg::ST_OCT: begin
                // corner hashes of the cell and t^2
                o_raddr0 = cell_x;
                o_raddr1 = cell_x + 8'd1;
                for (int k = 0; k < 3; k++) begin
                    sq = 32'(fr[k]) * 32'(fr[k]);
                    n_t2[k] = sq[31:16];
                end
                n_state = pno_pkg::ST_RD_A;
            end
            pno_pkg::ST_RD_A: begin
                ha       = i_rdata0 + cell_y;
                n_b      = i_rdata1 + cell_y;
                o_raddr0 = ha;
                o_raddr1 = ha + 8'd1;
                // t^3, and 6t^2 - 15t + 10 which stays positive on 0..1
                for (int k = 0; k < 3; k++) begin
                    cu = 32'(r_t2[k]) * 32'(fr[k]);
                    n_t3[k]   = cu[31:16];
                    n_poly[k] = 21'(r_t2[k]) * 21'd6 + 21'd655360 - 21'(fr[k]) * 21'd15;
                end
                n_state = pno_pkg::ST_RD_B;
            end
            pno_pkg::ST_RD_B: begin
                n_aa     = i_rdata0 + cell_z;
                n_ab     = i_rdata1 + cell_z;
                o_raddr0 = r_b;
                o_raddr1 = r_b + 8'd1;
                for (int k = 0; k < 3; k++) begin
                    fp = 37'(r_t3[k]) * 37'(r_poly[k]);
                    n_fade[k] = pno_pkg::t_wt'(fp >> pno_pkg::FRAC_BITS);
                end
                n_state = pno_pkg::ST_RD_AA;
            end
            pno_pkg::ST_RD_AA: begin
                n_ba     = i_rdata0 + cell_z;
                n_bb     = i_rdata1 + cell_z;
                o_raddr0 = r_aa;
                o_raddr1 = r_aa + 8'd1;
                n_state  = pno_pkg::ST_RD_AB;
            end
            pno_pkg::ST_RD_AB: begin
                n_h[0]   = i_rdata0;
                n_h[1]   = i_rdata1;
                o_raddr0 = r_ab;
                o_raddr1 = r_ab + 8'd1;
                n_state  = pno_pkg::ST_RD_BA;
            end
            pno_pkg::ST_RD_BA: begin
                n_h[2]   = i_rdata0;
                n_h[3]   = i_rdata1;
                o_raddr0 = r_ba;
                o_raddr1 = r_ba + 8'd1;
                n_state  = pno_pkg::ST_RD_BB;
            end
            pno_pkg::ST_RD_BB: begin
                n_h[4]   = i_rdata0;
                n_h[5]   = i_rdata1;
                o_raddr0 = r_bb;
                o_raddr1 = r_bb + 8'd1;
                n_state  = pno_pkg::ST_GRAD;
            end
            pno_pkg::ST_GRAD: begin
                // corner k: bit 2 picks x-1, bit 1 y-1, bit 0 z-1
                for (int k = 0; k < 8; k++) begin
                    n_g[k] = pno_pkg::grad(hh[k],
                                           ((k & 4) != 0) ? cx1 : cx0,
                                           ((k & 2) != 0) ? cy1 : cy0,
                                           ((k & 1) != 0) ? cz1 : cz0);
                end
                n_state = pno_pkg::ST_L1M;
            end
            pno_pkg::ST_L1M: begin
                for (int k = 0; k < 4; k++) begin
                    d = 20'(r_g[k + 4]) - 20'(r_g[k]);
                    n_p[k] = $signed({1'b0, r_fade[0]}) * d;
                end
                n_state = pno_pkg::ST_L1A;
            end
            pno_pkg::ST_L1A: begin
                for (int k = 0; k < 4; k++) begin
                    n_l[k] = pno_pkg::lerp_add(r_g[k], r_p[k]);
                end
                n_state = pno_pkg::ST_L2M;
            end
            pno_pkg::ST_L2M: begin
                for (int k = 0; k < 2; k++) begin
                    d = 20'(r_l[k + 2]) - 20'(r_l[k]);
                    n_p[k] = $signed({1'b0, r_fade[1]}) * d;
                end
                n_state = pno_pkg::ST_L2A;
            end
            pno_pkg::ST_L2A: begin
                for (int k = 0; k < 2; k++) begin
                    n_l[k] = pno_pkg::lerp_add(r_l[k], r_p[k]);
                end
                n_state = pno_pkg::ST_L3M;
            end
            pno_pkg::ST_L3M: begin
                d = 20'(r_l[1]) - 20'(r_l[0]);
                n_p[0]  = $signed({1'b0, r_fade[2]}) * d;
                n_state = pno_pkg::ST_L3A;
            end
            pno_pkg::ST_L3A: begin
                n_l[0]  = pno_pkg::lerp_add(r_l[0], r_p[0]);
                n_state = pno_pkg::ST_ACCM;
            end
            pno_pkg::ST_ACCM: begin
                // weight this octave, next amplitude
                n_sp    = r_l[0] * $signed({1'b0, r_amp});
                n_ampn  = 33'(r_amp) * 33'(i_persistence);
                n_state = pno_pkg::ST_ACCA;
            end
            pno_pkg::ST_ACCA: begin
                n_total = r_total + pno_pkg::t_tot'(r_sp >>> pno_pkg::FRAC_BITS);
                n_asum  = r_asum + pno_pkg::t_asum'(r_amp);
                n_amp   = pno_pkg::t_amp'(r_ampn >> 16);
                n_sx    = {r_sx[22:0], 1'b0};
                n_sy    = {r_sy[22:0], 1'b0};
                n_sz    = {r_sz[22:0], 1'b0};
                n_oct   = r_oct + 4'd1;
                if ((r_oct + 4'd1) == i_octaves)
                    n_state = pno_pkg::ST_FIN;
                else
                    n_state = pno_pkg::ST_OCT;
            end
            pno_pkg::ST_FIN: begin
                o_done  = 1'b1;
                n_state = pno_pkg::ST_IDLE;
            end
            default: begin
                n_state = pno_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_acc.total   = r_total;
    assign o_acc.amp_sum = r_asum;

endmodule

`default_nettype wire

// ===== hdl/pno_div.sv =====
`default_nettype none

module pno_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire pno_pkg::t_acc      i_acc,
    input  wire logic               i_normalize,
    input  wire logic               i_take,
    output logic                    o_valid,
    output logic signed [17:0]      o_value
);

    pno_pkg::t_div_st r_state, n_state;

    logic [19:0]  r_rem, n_rem;
    logic [19:0]  r_quo, n_quo;
    logic [19:0]  r_dvs, n_dvs;
    logic         r_neg, n_neg;
    logic [4:0]   r_cnt, n_cnt;
    logic signed [17:0] r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pno_pkg::DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    // Restoring divide of |total| * 2^16 by the amplitude sum, one bit a cycle
    always_comb begin
        logic [23:0] mag;
        logic [20:0] trial;
        logic signed [21:0] rs;
        logic signed [21:0] rn;

        n_state = r_state;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_res   = r_res;
        mag     = '0;
        trial   = '0;
        rs      = '0;
        rn      = '0;

        unique case (r_state)
            pno_pkg::DV_IDLE: begin
                if (i_start) begin
                    n_neg   = i_acc.total[23];
                    mag     = i_acc.total[23] ? 24'(-i_acc.total) : 24'(i_acc.total);
                    // quotient stays below 2^20, so the top part is below the divisor
                    n_rem   = 20'(mag[23:4]);
                    n_quo   = {mag[3:0], 16'b0};
                    n_dvs   = i_acc.amp_sum;
                    n_cnt   = '0;
                    n_state = pno_pkg::DV_RUN;
                end
            end
            pno_pkg::DV_RUN: begin
                trial = {r_rem, r_quo[19]} - {1'b0, r_dvs};
                if (!trial[20]) begin
                    n_rem = trial[19:0];
                    n_quo = {r_quo[18:0], 1'b1};
                end else begin
                    n_rem = {r_rem[18:0], r_quo[19]};
                    n_quo = {r_quo[18:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(pno_pkg::DIV_STEPS - 1))
                    n_state = pno_pkg::DV_FIN;
            end
            pno_pkg::DV_FIN: begin
                // sign, optional (v + 1) / 2, saturation
                rs = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
                rn = i_normalize ? ((rs + 22'sd65536) >>> 1) : rs;
                if (rn > 22'sd131071)
                    n_res = 18'sd131071;
                else if (rn < -22'sd131072)
                    n_res = -18'sd131072;
                else
                    n_res = 18'(rn);
                n_state = pno_pkg::DV_HOLD;
            end
            pno_pkg::DV_HOLD: begin
                if (i_take)
                    n_state = pno_pkg::DV_IDLE;
            end
            default: begin
                n_state = pno_pkg::DV_IDLE;
            end
        endcase
    end

    assign o_valid = (r_state == pno_pkg::DV_HOLD);
    assign o_value = r_res;

endmodule

`default_nettype wire

// ===== hdl/perlin_noise_3d_octaves_unit.sv =====
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_cmd, i_coord_x/y/z, i_entry_index/value
// out       output     o_out_valid / i_out_stall o_noise_value
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A table write item leaves the block ready again at once.
// An evaluate item runs, for each octave, the hash chain through the two table
// read ports and the shared lerp lanes, then the bit-serial divider and a
// rounding and hand-off step.
// One evaluate item is in work at a time; the output register holds a result
// while the next item runs. Reset clears control only; table undefined until written.
`default_nettype none

module perlin_noise_3d_octaves_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_cmd,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic [7:0]         i_entry_index,
    input  wire logic [7:0]         i_entry_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [17:0]      o_noise_value,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    logic        r_busy, n_busy;
    logic [3:0]  r_octaves;
    logic [15:0] r_pers;
    logic        r_norm;
    logic        r_out_valid, n_out_valid;
    logic signed [17:0] r_out_value;

    logic        in_acc, take, eng_done, div_valid;
    logic [7:0]  raddr0, raddr1, rdata0, rdata1;
    logic signed [17:0] div_value;
    pno_pkg::t_acc acc;

    assign in_acc      = i_in_valid && !r_busy;
    assign take        = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;

    // Configuration registers, octave count clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= 4'd1;
            r_pers    <= 16'd32768;
            r_norm    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pno_pkg::CFG_OCTAVES: begin
                    if (i_cfg_data[3:0] == 4'd0)
                        r_octaves <= 4'd1;
                    else if (i_cfg_data[3:0] > 4'(pno_pkg::MAX_OCTAVES))
                        r_octaves <= 4'(pno_pkg::MAX_OCTAVES);
                    else
                        r_octaves <= i_cfg_data[3:0];
                end
                pno_pkg::CFG_PERSIST:   r_pers <= i_cfg_data;
                pno_pkg::CFG_NORMALIZE: r_norm <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Busy from evaluate accept until the result moves to the output register
    always_comb begin
        n_busy = r_busy;
        if (in_acc && i_cmd == pno_pkg::CMD_EVAL)
            n_busy = 1'b1;
        else if (div_valid && take)
            n_busy = 1'b0;

        n_out_valid = r_out_valid;
        if (div_valid && take)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_valid && take) begin
            r_out_value <= div_value;
        end
    end

    pno_ram #(
        .WIDTH (8),
        .DEPTH (pno_pkg::TABLE_SIZE)
    ) u_perm (
        .i_clk    (i_clk),
        .i_we     (in_acc && i_cmd == pno_pkg::CMD_WRITE),
        .i_waddr  (i_entry_index),
        .i_wdata  (i_entry_value),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    pno_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_acc && i_cmd == pno_pkg::CMD_EVAL),
        .i_cx          (i_coord_x),
        .i_cy          (i_coord_y),
        .i_cz          (i_coord_z),
        .i_octaves     (r_octaves),
        .i_persistence (r_pers),
        .i_rdata0      (rdata0),
        .i_rdata1      (rdata1),
        .o_raddr0      (raddr0),
        .o_raddr1      (raddr1),
        .o_done        (eng_done),
        .o_acc         (acc)
    );

    pno_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (eng_done),
        .i_acc       (acc),
        .i_normalize (r_norm),
        .i_take      (take),
        .o_valid     (div_valid),
        .o_value     (div_value)
    );

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out_value;

endmodule

`default_nettype wire

// ===== hdl/pno_checker.sv =====
`default_nettype none
`include "perlin_noise_3d_octaves_unit_macros.svh"

module pno_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               i_cmd,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [17:0] o_noise_value
);

    // An evaluate item occupies the block
    `PNO_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_cmd, o_in_stall, "evaluate item did not stall the input")

    // A table write leaves the block ready
    `PNO_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_cmd, !o_in_stall, "table write stalled the input")

    // A result appears only at the end of an evaluation
    `PNO_ASSERT_SAME(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without an evaluation in work")

    // A stalled result holds
    `PNO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_noise_value), "stalled result changed")

endmodule

bind perlin_noise_3d_octaves_unit pno_checker u_pno_checker (.*);

`default_nettype wire
